FILE: rtl/core/blk2_pkg.sv
// ----------------------------------------------------------------------------
// blk2_pkg
// Shared types and constants of the BLAKE2b stream hasher: initialization
// vector, message schedule, controller states and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package blk2_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned Rounds  = 12;
  localparam logic [63:0] ParamWord = 64'h0000_0000_0101_0000;
  localparam logic [6:0]  MaxDigest = 7'd64;

  localparam logic [63:0] IV [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
    64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOADV,
    ST_ROUND,
    ST_FEED,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       wr_in;
    logic       save_pend;
    logic       wr_pend;
    logic       cnt_full;
    logic       cnt_fin;
    logic       cnt_one;
    logic       load_v;
    logic       final_blk;
    logic       round_en;
    logic [3:0] round;
    logic [1:0] step;
    logic       feed;
    logic       shift_out;
    logic       init;
  } cmd_t;

  typedef struct packed {
    logic       full;
    logic       pend_eom;
    logic [5:0] last_idx;
  } sts_t;

  function automatic logic [6:0] eff_len(logic [6:0] d);
    logic [6:0] r;
    r = d;
    if (d == 7'd0) r = 7'd1;
    else if (d > MaxDigest) r = MaxDigest;
    return r;
  endfunction

endpackage

FILE: rtl/core/blk2_ctrl.sv
// ----------------------------------------------------------------------------
// blk2_ctrl
// Controller of the BLAKE2b stream hasher: sequences byte intake, the
// twelve-round compression and the digest output.
// ----------------------------------------------------------------------------
module blk2_ctrl import blk2_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_has_data,
  input  logic in_end_of_message,
  output logic out_valid,
  input  logic out_ready,
  output logic out_last_byte,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic       final_r, final_nxt;
  logic [3:0] round_r, round_nxt;
  logic [1:0] step_r, step_nxt;
  logic [5:0] ocnt_r, ocnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      final_r <= 1'b0;
      round_r <= '0;
      step_r  <= '0;
      ocnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      final_r <= final_nxt;
      round_r <= round_nxt;
      step_r  <= step_nxt;
      ocnt_r  <= ocnt_nxt;
    end
  end

  assign out_last_byte = (ocnt_r == sts.last_idx);

  always_comb begin
    state_nxt = state_r;
    final_nxt = final_r;
    round_nxt = round_r;
    step_nxt  = step_r;
    ocnt_nxt  = ocnt_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    cmd.round = round_r;
    cmd.step  = step_r;
    cmd.final_blk = final_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_has_data && sts.full) begin
            cmd.save_pend = 1'b1;
            cmd.cnt_full  = 1'b1;
            final_nxt     = 1'b0;
            state_nxt     = ST_LOADV;
          end else begin
            cmd.wr_in = in_has_data;
            if (in_end_of_message) begin
              cmd.cnt_fin = 1'b1;
              final_nxt   = 1'b1;
              state_nxt   = ST_LOADV;
            end
          end
        end
      end
      ST_LOADV: begin
        cmd.load_v = 1'b1;
        round_nxt  = '0;
        step_nxt   = '0;
        state_nxt  = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        step_nxt     = step_r + 2'd1;
        if (step_r == 2'd3) begin
          round_nxt = round_r + 4'd1;
          if (round_r == 4'(Rounds - 1)) state_nxt = ST_FEED;
        end
      end
      ST_FEED: begin
        cmd.feed = 1'b1;
        ocnt_nxt = '0;
        if (final_r) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.wr_pend = 1'b1;
          if (sts.pend_eom) begin
            cmd.cnt_one = 1'b1;
            final_nxt   = 1'b1;
            state_nxt   = ST_LOADV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.shift_out = 1'b1;
          ocnt_nxt      = ocnt_r + 6'd1;
          if (out_last_byte) begin
            cmd.init  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output active together");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && step_r == 2'd3 && round_r == 4'(Rounds - 1))
    |=> state_r == ST_FEED) else $error("compression did not end after last round");

  a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_byte) |=> state_r == ST_IDLE)
    else $error("block not idle after last digest byte");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |-> round_r < 4'(Rounds)) else $error("round out of range");

endmodule

FILE: rtl/core/blk2_dp.sv
// ----------------------------------------------------------------------------
// blk2_dp
// Datapath of the BLAKE2b stream hasher: block buffer, byte counter, chain
// value, work vector with four mixing lanes and the digest shift register.
// ----------------------------------------------------------------------------
module blk2_dp import blk2_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  input  logic [7:0] in_data_byte,
  input  logic       in_has_data,
  input  logic       in_end_of_message,
  output logic [7:0] out_digest_byte,
  input  cmd_t       cmd,
  output sts_t       sts
);

  logic [6:0]  dl_r;
  logic [63:0] h_r [8];
  logic [63:0] v_r [16];
  logic [63:0] v_nxt [16];
  logic [63:0] m_r [16];
  logic [63:0] cnt_lo_r, cnt_hi_r;
  logic [7:0]  fill_r;
  logic [7:0]  pend_byte_r;
  logic        pend_eom_r;
  logic [511:0] osh_r;
  logic [7:0]  cnt_amt;
  logic        cnt_add;
  logic [64:0] lo_sum;
  logic [6:0]  new_len;
  logic [63:0] h_fed [8];
  logic [3:0]  rm;

  assign sts.full     = fill_r[7];
  assign sts.pend_eom = pend_eom_r;
  assign sts.last_idx = 6'(eff_len(dl_r) - 7'd1);
  assign out_digest_byte = osh_r[7:0];

  assign new_len = cfg_we ? eff_len(cfg_wdata) : eff_len(dl_r);

  always_comb begin
    cnt_add = 1'b1;
    cnt_amt = 8'd0;
    if (cmd.cnt_full) cnt_amt = 8'd128;
    else if (cmd.cnt_fin) cnt_amt = fill_r + {7'd0, in_has_data};
    else if (cmd.cnt_one) cnt_amt = 8'd1;
    else cnt_add = 1'b0;
    lo_sum = {1'b0, cnt_lo_r} + {57'd0, cnt_amt};
  end

  always_comb begin
    for (int i = 0; i < 8; i++) h_fed[i] = h_r[i] ^ v_r[i] ^ v_r[i + 8];
  end

  assign rm = (cmd.round >= 4'd10) ? cmd.round - 4'd10 : cmd.round;

  always_comb begin
    logic [3:0]  ia, ib, ic, id, k;
    logic [63:0] a, b, c, d, x, t;
    for (int i = 0; i < 16; i++) v_nxt[i] = v_r[i];
    for (int l = 0; l < 4; l++) begin
      ia = 4'(l);
      if (cmd.step[1]) begin
        ib = 4'd4 + 4'((l + 1) % 4);
        ic = 4'd8 + 4'((l + 2) % 4);
        id = 4'd12 + 4'((l + 3) % 4);
        k  = 4'd8 + 4'(2 * l) + {3'd0, cmd.step[0]};
      end else begin
        ib = 4'd4 + 4'(l);
        ic = 4'd8 + 4'(l);
        id = 4'd12 + 4'(l);
        k  = 4'(2 * l) + {3'd0, cmd.step[0]};
      end
      x = m_r[SIGMA[rm][k]];
      a = v_r[ia] + v_r[ib] + x;
      t = v_r[id] ^ a;
      if (cmd.step[0]) d = {t[15:0], t[63:16]};
      else d = {t[31:0], t[63:32]};
      c = v_r[ic] + d;
      t = v_r[ib] ^ c;
      if (cmd.step[0]) b = {t[62:0], t[63]};
      else b = {t[23:0], t[63:24]};
      v_nxt[ia] = a;
      v_nxt[ib] = b;
      v_nxt[ic] = c;
      v_nxt[id] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_r       <= MaxDigest;
      fill_r     <= '0;
      cnt_lo_r   <= '0;
      cnt_hi_r   <= '0;
      pend_eom_r <= 1'b0;
      for (int i = 1; i < 8; i++) h_r[i] <= IV[i];
      h_r[0] <= IV[0] ^ ParamWord ^ {57'd0, MaxDigest};
    end else if (cfg_we || cmd.init) begin
      if (cfg_we) dl_r <= cfg_wdata;
      fill_r   <= '0;
      cnt_lo_r <= '0;
      cnt_hi_r <= '0;
      for (int i = 1; i < 8; i++) h_r[i] <= IV[i];
      h_r[0] <= IV[0] ^ ParamWord ^ {57'd0, new_len};
    end else begin
      if (cnt_add) begin
        cnt_lo_r <= lo_sum[63:0];
        cnt_hi_r <= cnt_hi_r + {63'd0, lo_sum[64]};
      end
      if (cmd.wr_in) fill_r <= fill_r + 8'd1;
      if (cmd.wr_pend) fill_r <= 8'd1;
      if (cmd.save_pend) pend_eom_r <= in_end_of_message;
      if (cmd.feed) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_fed[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_pend) pend_byte_r <= in_data_byte;
    if (cmd.wr_in) m_r[fill_r[6:3]][8 * fill_r[2:0] +: 8] <= in_data_byte;
    if (cmd.wr_pend) m_r[0][7:0] <= pend_byte_r;
    if (cmd.load_v && cmd.final_blk) begin
      for (int w = 0; w < 16; w++) begin
        for (int j = 0; j < 8; j++) begin
          if ({1'b0, 4'(w), 3'(j)} >= fill_r) m_r[w][8 * j +: 8] <= 8'd0;
        end
      end
    end
    if (cmd.load_v) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      for (int i = 0; i < 4; i++) v_r[i + 8] <= IV[i];
      v_r[12] <= IV[4] ^ cnt_lo_r;
      v_r[13] <= IV[5] ^ cnt_hi_r;
      v_r[14] <= cmd.final_blk ? ~IV[6] : IV[6];
      v_r[15] <= IV[7];
    end else if (cmd.round_en) begin
      for (int i = 0; i < 16; i++) v_r[i] <= v_nxt[i];
    end
    if (cmd.feed) begin
      osh_r <= {h_fed[7], h_fed[6], h_fed[5], h_fed[4],
                h_fed[3], h_fed[2], h_fed[1], h_fed[0]};
    end else if (cmd.shift_out) begin
      osh_r <= {8'd0, osh_r[511:8]};
    end
  end

endmodule

FILE: rtl/core/blake2b_stream_hasher.sv
// ----------------------------------------------------------------------------
// blake2b_stream_hasher
// Unkeyed BLAKE2b hasher over a byte stream with a configurable digest size.
//
// The input channel takes one transaction per cycle while the block buffer
// fills: a message byte (when in_has_data is set) and an end-of-message flag.
// A byte arriving on a full 128-byte buffer first triggers a non-final
// compression (vector load, twelve rounds of four steps on four shared
// mixing lanes, feed-forward); in_ready is low during that time.
// End of message pads the buffer and runs the final compression the same way,
// after which the digest leaves on the output channel one byte per
// transaction, least significant byte of chain word zero first, with
// out_last_byte set on the last byte. The first digest byte is offered
// after the final compression, which follows a non-final one when the
// end-of-message transaction starts one; then one byte per cycle follows
// while out_ready is high. A stalled receiver simply holds the current
// byte; no input is taken until the digest is fully delivered.
// Reset and every cfg_we write reinitialize the chain value, counter and
// buffer; the digest length resets to 64 bytes.
// ----------------------------------------------------------------------------
module blake2b_stream_hasher import blk2_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_has_data,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_digest_byte,
  output logic       out_last_byte
);

  cmd_t cmd;
  sts_t sts;

  blk2_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_has_data       (in_has_data),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_last_byte     (out_last_byte),
    .sts               (sts),
    .cmd               (cmd)
  );

  blk2_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_data_byte      (in_data_byte),
    .in_has_data       (in_has_data),
    .in_end_of_message (in_end_of_message),
    .out_digest_byte   (out_digest_byte),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
